### hw/rtl/inv_pkg.sv
// inv_pkg: shared sizes, handshake structs and the sort state encoding
// for the inversion counter. No dependencies.

package inv_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 19;
    localparam int SUM_W     = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
    localparam int OUT_W     = ((COUNT_W + 1 + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // sort request from the load side
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] n;
    } sort_cmd_t;

    // sort engine status back to the load side
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [COUNT_W-1:0] total;
    } sort_stat_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SEG  = 5'b00010,
        S_RD   = 5'b00100,
        S_MRG  = 5'b01000,
        S_DONE = 5'b10000
    } sort_state_t;

endpackage

### hw/rtl/inversion_counter.sv
// inversion_counter: top level. Loads a set of signed words, merge-sorts it
// and reports the inversion count. Depends on inv_pkg and inv_sort_engine.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------
//  s_axis  | in  | s_axis_tvalid/tready  | tdata = value, tlast = last
//  m_axis  | out | m_axis_tvalid/tready  | tdata = inversion_count, overflowed
//
// Loading takes one transfer per cycle while s_axis_tready is high, written
// straight into RAM bank 0. The transfer with tlast starts the sort:
// ceil(log2 n) passes, each an S_SEG step per run pair, then per element
// S_RD (two-port RAM read) and S_MRG (compare and write); input is held off
// meanwhile. The result sits in an output register; the next set may load
// while it waits, but its sort starts only once that result is taken.
// Reset (rst_n low, asynchronous) empties the set; RAM contents are not
// cleared. Elements beyond MAX_ITEMS are dropped and reported as overflowed.

module inversion_counter
    import inv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,  // [31:0] value
    input  logic             s_axis_tlast,  // last
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata   // [18:0] inversion_count, [19] overflowed
);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               drop_reg, drop_next;
    logic               sort_req_reg, sort_req_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               in_xfer, store_ok;
    sort_cmd_t          cmd;
    sort_stat_t         stat;

    assign s_axis_tready = !sort_req_reg && !stat.busy;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign store_ok      = (count_reg < CNT_W'(MAX_ITEMS));

    // start once the output register is free so the result has a slot
    assign cmd.start = sort_req_reg && !out_valid_reg;
    assign cmd.n     = count_reg;

    always_comb
    begin
        count_next     = count_reg;
        drop_next      = drop_reg;
        sort_req_next  = sort_req_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;

        if (in_xfer)
        begin
            if (store_ok)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                drop_next = 1'b1;
            end
            if (s_axis_tlast)
            begin
                sort_req_next = 1'b1;
            end
        end

        if (cmd.start)
        begin
            sort_req_next = 1'b0;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // count and drop flag stay put during the sort, cleared with the result
        if (stat.done)
        begin
            out_valid_next = 1'b1;
            out_count_next = stat.total;
            out_ovf_next   = drop_reg;
            count_next     = '0;
            drop_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            sort_req_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            sort_req_reg  <= sort_req_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    inv_sort_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_we   (in_xfer && store_ok),
        .load_addr (count_reg[ADDR_W-1:0]),
        .load_data (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_ovf_reg, out_count_reg});

endmodule

### hw/rtl/inv_ram.sv
// inv_ram: generic RAM, one write port and two registered read ports.
// No dependencies.

module inv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### hw/rtl/inv_sort_engine.sv
// inv_sort_engine: bottom-up merge sort over two ping-pong RAM banks,
// counting inversions as it merges. Depends on inv_pkg and inv_ram.

module inv_sort_engine
    import inv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_we,
    input  logic [ADDR_W-1:0] load_addr,
    input  logic [DATA_W-1:0] load_data,
    input  sort_cmd_t         cmd,
    output sort_stat_t        stat
);

    localparam int EXT_W = CNT_W + 2;

    sort_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W:0]     width_reg, width_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   rt_reg, rt_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               src_reg, src_next;

    logic [DATA_W-1:0]  b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b;
    logic [DATA_W-1:0]  head_l, head_r, wr_data;
    logic               take_right, mrg_we;
    logic               b0_we, b1_we;
    logic [ADDR_W-1:0]  b0_waddr;
    logic [DATA_W-1:0]  b0_wdata;
    logic [EXT_W-1:0]   n_ext, lo_w, lo_2w, w2;
    logic [SUM_W-1:0]   sum;

    assign n_ext = EXT_W'(n_reg);
    assign lo_w  = EXT_W'(lo_reg) + EXT_W'(width_reg);
    assign w2    = EXT_W'(width_reg) << 1;
    assign lo_2w = EXT_W'(lo_reg) + w2;

    assign head_l = src_reg ? b1_rd_a : b0_rd_a;
    assign head_r = src_reg ? b1_rd_b : b0_rd_b;

    // left run empty, or right head strictly smaller than left head
    assign take_right = (i_reg >= mid_reg) ||
                        ((j_reg < hi_reg) && ($signed(head_l) > $signed(head_r)));
    assign wr_data    = take_right ? head_r : head_l;
    assign mrg_we     = (state_reg == S_MRG);
    assign sum        = SUM_W'(total_reg) + SUM_W'(rt_reg);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        rt_next    = rt_reg;
        total_next = total_reg;
        src_next   = src_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    n_next     = cmd.n;
                    width_next = (CNT_W+1)'(1);
                    lo_next    = '0;
                    total_next = '0;
                    src_next   = 1'b0;
                    state_next = (cmd.n > CNT_W'(1)) ? S_SEG : S_DONE;
                end
            end
            S_SEG:
            begin
                mid_next   = (lo_w < n_ext) ? lo_w[CNT_W-1:0] : n_reg;
                hi_next    = (lo_2w < n_ext) ? lo_2w[CNT_W-1:0] : n_reg;
                i_next     = lo_reg;
                j_next     = (lo_w < n_ext) ? lo_w[CNT_W-1:0] : n_reg;
                k_next     = lo_reg;
                rt_next    = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_MRG;
            end
            S_MRG:
            begin
                k_next = k_reg + 1'b1;
                if (take_right)
                begin
                    j_next  = j_reg + 1'b1;
                    rt_next = rt_reg + 1'b1;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    // saturate at the largest reportable count
                    total_next = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
                end
                if ((k_reg + 1'b1) == hi_reg)
                begin
                    if (lo_2w < n_ext)
                    begin
                        lo_next    = lo_2w[CNT_W-1:0];
                        state_next = S_SEG;
                    end
                    else
                    begin
                        // pass finished: swap banks, double run length unless this was the last pass
                        src_next = ~src_reg;
                        lo_next  = '0;
                        if (w2 < n_ext)
                        begin
                            width_next = w2[CNT_W:0];
                            state_next = S_SEG;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            src_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            src_reg   <= src_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        rt_reg    <= rt_next;
    end

    // bank 0 takes loads while idle, merge writes when it is the target
    assign b0_we    = load_we || (mrg_we && src_reg);
    assign b0_waddr = load_we ? load_addr : k_reg[ADDR_W-1:0];
    assign b0_wdata = load_we ? load_data : wr_data;
    assign b1_we    = mrg_we && !src_reg;

    inv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_bank0 (
        .clk     (clk),
        .we      (b0_we),
        .waddr   (b0_waddr),
        .wdata   (b0_wdata),
        .raddr_a (i_reg[ADDR_W-1:0]),
        .rdata_a (b0_rd_a),
        .raddr_b (j_reg[ADDR_W-1:0]),
        .rdata_b (b0_rd_b)
    );

    inv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_bank1 (
        .clk     (clk),
        .we      (b1_we),
        .waddr   (k_reg[ADDR_W-1:0]),
        .wdata   (wr_data),
        .raddr_a (i_reg[ADDR_W-1:0]),
        .rdata_a (b1_rd_a),
        .raddr_b (j_reg[ADDR_W-1:0]),
        .rdata_b (b1_rd_b)
    );

    assign stat.busy  = (state_reg != S_IDLE);
    assign stat.done  = (state_reg == S_DONE);
    assign stat.total = total_reg;

endmodule
